@@ hw/rtl/evba_pkg.sv @@
// ----------------------------------------------------------------------------
// egress vc byte admission package
// Shared sizes, operation codes and register indexes for the admission block.
// ----------------------------------------------------------------------------
`default_nettype none

package evba_pkg;

   // table geometry
   localparam int NUM_PORTS = 16;
   localparam int NUM_VCS   = 8;
   localparam int ENTRIES   = NUM_PORTS * NUM_VCS;
   localparam int ENTRY_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // field widths
   localparam int FUNC_W   = 2;
   localparam int PORT_W   = 4;
   localparam int VC_W     = 3;
   localparam int BYTES_W  = 16;
   localparam int COUNT_W  = 32;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;

   // configuration port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_DROP_POLICY = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_QUEUE_MAX   = 1'd1;
   localparam logic [COUNT_W-1:0]    QUEUE_MAX_RESET = 32'd1048576;

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_RESERVE = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_QUERY   = 2'd2
   } func_type;

endpackage

`default_nettype wire

@@ hw/rtl/egress_vc_byte_admission.sv @@
// ----------------------------------------------------------------------------
// egress vc byte admission
// Per port and virtual channel reserved-byte counters with drop admission.
// ----------------------------------------------------------------------------
//  channel  | ports          | direction | contents
//  request  | req_t*         | in        | reserve, release or query transaction
//  response | rsp_t*         | out       | accepted flag and counter after the op
//  config   | csr_*          | in        | drop_policy, queue_max_bytes writes
//
//  one transaction per cycle while the response is not stalled; a response
//  follows the counter table read, then the update and response register
//  the counter table is a 128 x 32 memory with one valid bit per entry;
//  reset clears the valid bits at once, so a never-written entry reads zero
//  a stalled response holds the pipeline stage behind it; back-to-back hits
//  on one entry are forwarded from the update stage to the read
// ----------------------------------------------------------------------------
`default_nettype none

module egress_vc_byte_admission (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   // request: port_index, vc_index, byte_count, queued_bytes, target_present
   input  wire  logic [evba_pkg::REQ_DATA_W-1:0]     req_tdata,
   // request: func
   input  wire  logic [evba_pkg::FUNC_W-1:0]         req_tuser,
   input  wire  logic                                req_tvalid,
   output       logic                                req_tready,
   // response: accepted, reserved_total, zero pad
   output       logic [evba_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output       logic                                rsp_tvalid,
   input  wire  logic                                rsp_tready,
   input  wire  logic                                csr_wen,
   input  wire  logic [evba_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire  logic [evba_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import evba_pkg::*;

   // configuration registers
   logic               drop_policy_ff;
   logic [COUNT_W-1:0] queue_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_policy_ff <= 1'b0;
         queue_max_ff   <= QUEUE_MAX_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_DROP_POLICY: drop_policy_ff <= csr_wdata[0];
            CSR_QUEUE_MAX:   queue_max_ff   <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // request field unpack
   logic [PORT_W-1:0]  req_port;
   logic [VC_W-1:0]    req_vc;
   logic [BYTES_W-1:0] req_bytes;
   logic [COUNT_W-1:0] req_queued;
   logic               req_present;
   logic               req_in_range;
   logic [ENTRY_W-1:0] req_idx;

   assign req_port    = req_tdata[PORT_W-1:0];
   assign req_vc      = req_tdata[PORT_W+VC_W-1:PORT_W];
   assign req_bytes   = req_tdata[PORT_W+VC_W+BYTES_W-1:PORT_W+VC_W];
   assign req_queued  = req_tdata[PORT_W+VC_W+BYTES_W+COUNT_W-1:PORT_W+VC_W+BYTES_W];
   assign req_present = req_tdata[PORT_W+VC_W+BYTES_W+COUNT_W];

   assign req_in_range = (int'(req_port) < NUM_PORTS) && (int'(req_vc) < NUM_VCS);
   assign req_idx      = ENTRY_W'(int'(req_port) * NUM_VCS + int'(req_vc));

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic req_take;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // stage one payload, captured with the table read
   func_type           s1_func_ff;
   logic [BYTES_W-1:0] s1_bytes_ff;
   logic [COUNT_W-1:0] s1_queued_ff;
   logic               s1_present_ff;
   logic               s1_in_range_ff;
   logic [ENTRY_W-1:0] s1_idx_ff;
   logic               s1_hit_ff, s1_hit_in;
   logic [COUNT_W-1:0] s1_fwd_ff;
   logic               s1_entry_vld_ff;

   // counter table and its valid bits
   logic [COUNT_W-1:0] table_mem [ENTRIES];
   logic [COUNT_W-1:0] table_rd_ff;
   logic [ENTRIES-1:0] entry_vld_ff;
   logic               table_we;
   logic [COUNT_W-1:0] new_count;

   always_ff @(posedge clock) begin
      if (table_we) begin
         table_mem[s1_idx_ff] <= new_count;
      end
      if (req_take) begin
         table_rd_ff <= table_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (table_we) begin
         entry_vld_ff[s1_idx_ff] <= 1'b1;
      end
   end

   // forward an update that lands in the same cycle as the read
   assign s1_hit_in = table_we && (s1_idx_ff == req_idx);

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff      <= func_type'(req_tuser);
         s1_bytes_ff     <= req_bytes;
         s1_queued_ff    <= req_queued;
         s1_present_ff   <= req_present;
         s1_in_range_ff  <= req_in_range;
         s1_idx_ff       <= req_idx;
         s1_hit_ff       <= s1_hit_in;
         s1_fwd_ff       <= new_count;
         s1_entry_vld_ff <= entry_vld_ff[req_idx];
      end
   end

   // current counter value of the addressed entry
   logic [COUNT_W-1:0] cur_count;

   always_comb begin
      priority if (!s1_in_range_ff) begin
         cur_count = '0;
      end else if (s1_hit_ff) begin
         cur_count = s1_fwd_ff;
      end else if (s1_entry_vld_ff) begin
         cur_count = table_rd_ff;
      end else begin
         cur_count = '0;
      end
   end

   // admission decision and counter update
   logic [COUNT_W+1:0] projected;
   logic               over_max;
   logic               accepted;
   logic               write_op;

   assign projected = {2'b00, s1_queued_ff} + {2'b00, cur_count}
                    + (COUNT_W+2)'(s1_bytes_ff);
   assign over_max  = projected > {2'b00, queue_max_ff};

   always_comb begin
      accepted  = 1'b1;
      write_op  = 1'b0;
      new_count = cur_count;
      unique case (s1_func_ff)
         FUNC_RESERVE: begin
            if (drop_policy_ff) begin
               if (!s1_present_ff || !s1_in_range_ff || over_max) begin
                  accepted = 1'b0;
               end else begin
                  write_op  = 1'b1;
                  new_count = cur_count + COUNT_W'(s1_bytes_ff);
               end
            end
         end
         FUNC_RELEASE: begin
            write_op  = s1_in_range_ff;
            new_count = (cur_count <= COUNT_W'(s1_bytes_ff)) ? '0
                      : cur_count - COUNT_W'(s1_bytes_ff);
         end
         default: ;
      endcase
   end

   assign table_we = s1_valid_ff && advance && write_op;

   // valid flags
   assign s1_valid_in  = req_take ? 1'b1 : (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response register
   logic               rsp_accepted_ff;
   logic [COUNT_W-1:0] rsp_total_ff;

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_accepted_ff <= accepted;
         rsp_total_ff    <= new_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-COUNT_W-1)'(0), rsp_total_ff, rsp_accepted_ff};

`ifndef SYNTHESIS
   // reset leaves every counter entry reading as zero
   a_reset_clears_valid: assert property (@(posedge clock)
      $past(reset) |-> (entry_vld_ff == '0))
      else $error("valid bits not cleared by reset");

   // an admitted reserve never takes the counter past the configured maximum
   a_reserve_within_max: assert property (@(posedge clock) disable iff (reset)
      (table_we && (s1_func_ff == FUNC_RESERVE)) |-> (new_count <= queue_max_ff))
      else $error("reserve admitted beyond queue maximum");

   // a stalled response keeps the stage behind it occupied
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |=> s1_valid_ff)
      else $error("stage one dropped a transaction under stall");

   // a refused reserve leaves the table untouched
   a_refused_no_write: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !accepted) |-> !table_we)
      else $error("refused reserve wrote the counter table");
`endif

endmodule

`default_nettype wire

@@ tb/evba_admission_checker.sv @@
// ----------------------------------------------------------------------------
// egress vc byte admission checker
// Watches the request, response and register ports and keeps its own copy of
// the per port and virtual channel reserved-byte counters. Each accepted
// request gets an expected response, and each response is compared in order.
// ----------------------------------------------------------------------------
module evba_admission_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [evba_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [evba_pkg::FUNC_W-1:0]     req_tuser,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [evba_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wen,
   input  logic [evba_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [evba_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              backlog,
   output int                              checked_count,
   output int                              refused_count
);
   import evba_pkg::*;

   localparam int REPORT_LIMIT = 100;

   // request fields, port_index in the lowest bits
   typedef struct packed {
      logic               present;
      logic [COUNT_W-1:0] queued;
      logic [BYTES_W-1:0] nbytes;
      logic [VC_W-1:0]    vc;
      logic [PORT_W-1:0]  port;
   } admit_request_type;

   typedef struct packed {
      logic               accepted;
      logic [COUNT_W-1:0] total;
   } admit_result_type;

   admit_result_type   expected_admissions[$];
   logic [COUNT_W-1:0] reserved_tally[ENTRIES];
   logic               drop_mode;
   logic [COUNT_W-1:0] queue_limit;
   int                 reported;

   // one request against the counter table; updates the table on a release or an admitted drop-policy reserve
   function automatic admit_result_type predict_admission(input logic [FUNC_W-1:0] op,
                                                          input admit_request_type rq);
      int                 slot;
      logic [COUNT_W-1:0] level;
      logic [COUNT_W+1:0] projected;
      admit_result_type   res;
      slot = int'(rq.port) * NUM_VCS + int'(rq.vc);
      level = reserved_tally[slot];
      res.accepted = 1'b1;
      case (op)
         FUNC_RESERVE: begin
            // retry policy admits without touching the counter
            if (drop_mode) begin
               projected = (COUNT_W+2)'(rq.queued) + (COUNT_W+2)'(level)
                         + (COUNT_W+2)'(rq.nbytes);
               if (!rq.present || projected > (COUNT_W+2)'(queue_limit)) begin
                  res.accepted = 1'b0;
               end else begin
                  level = level + COUNT_W'(rq.nbytes);
                  reserved_tally[slot] = level;
               end
            end
         end
         FUNC_RELEASE: begin
            // saturate at zero
            level = (level <= COUNT_W'(rq.nbytes)) ? '0 : level - COUNT_W'(rq.nbytes);
            reserved_tally[slot] = level;
         end
         default: begin
            // query and the unused code leave the counter alone
         end
      endcase
      res.total = level;
      return res;
   endfunction

   task automatic report_field(input string what, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
      fail_count++;
      if (reported < REPORT_LIMIT) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      end
      reported++;
   endtask

   // track registers, predict on request, compare on response
   always @(posedge clock) begin
      admit_result_type want;
      if (reset) begin
         foreach (reserved_tally[i]) reserved_tally[i] = '0;
         drop_mode = 1'b0;
         queue_limit = QUEUE_MAX_RESET;
         expected_admissions.delete();
         fail_count = 0;
         backlog = 0;
         checked_count = 0;
         refused_count = 0;
         reported = 0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_DROP_POLICY: drop_mode = csr_wdata[0];
               CSR_QUEUE_MAX:   queue_limit = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_admissions.size() == 0) begin
               fail_count++;
               if (reported < REPORT_LIMIT) begin
                  $display("%0t: response expected none actual accepted %0d total %0d",
                           $time, rsp_tdata[0], rsp_tdata[COUNT_W:1]);
               end
               reported++;
            end else begin
               // oldest expected response first
               want = expected_admissions[0];
               expected_admissions.delete(0);
               checked_count++;
               if (!want.accepted) refused_count++;
               if (rsp_tdata[0] !== want.accepted) begin
                  report_field("accepted", COUNT_W'(want.accepted), COUNT_W'(rsp_tdata[0]));
               end
               if (rsp_tdata[COUNT_W:1] !== want.total) begin
                  report_field("reserved_total", want.total, rsp_tdata[COUNT_W:1]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_admissions.insert(expected_admissions.size(),
               predict_admission(req_tuser, admit_request_type'(req_tdata)));
         end
         backlog = expected_admissions.size();
      end
   end

endmodule

@@ tb/egress_vc_byte_admission_tb.sv @@
// ----------------------------------------------------------------------------
// egress vc byte admission testbench
// Drives reserve, release and query transactions in random bursts under
// several admission settings, stalls the response side on its own pattern,
// and takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module egress_vc_byte_admission_tb;
   import evba_pkg::*;

   localparam int                CYCLE_LIMIT     = 150000;
   localparam int                HOLD_OFF_CYCLES = 200;
   localparam int                DRAIN_CYCLES    = 6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE      = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                    fail_count;
   int                    backlog;
   int                    checked_count;
   int                    refused_count;
   int                    cycle_count = 0;
   int                    burst_left = 1;
   logic                  hold_off_req = 1'b0;
   logic [COUNT_W-1:0]    cur_max = QUEUE_MAX_RESET;

   always #2 clock = ~clock;

   egress_vc_byte_admission dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   evba_admission_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_wen       (csr_wen),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .backlog       (backlog),
      .checked_count (checked_count),
      .refused_count (refused_count)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, backlog);
         $display("Mismatches found");
         $finish;
      end
   end

   // response side: long hold-off on request, otherwise random segments
   initial begin
      int seg_mode;
      int seg_len;
      forever begin
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            seg_mode = $urandom_range(0, 3);
            seg_len = $urandom_range(1, 24);
            repeat (seg_len) begin
               case (seg_mode)
                  0, 1:    rsp_tready <= 1'b1;
                  2:       rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= 1'b0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // offer one transaction, then maybe close the burst with a gap
   task automatic offer_txn(input logic [FUNC_W-1:0] op, input logic [PORT_W-1:0] port,
                            input logic [VC_W-1:0] vc, input logic [BYTES_W-1:0] nbytes,
                            input logic [COUNT_W-1:0] queued, input logic present);
      int gap;
      req_tuser <= op;
      req_tdata <= {present, queued, nbytes, vc, port};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // stop sending and let every response come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (backlog == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_addr <= addr;
      csr_wdata <= data;
      csr_wen <= 1'b1;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_policy(input logic drop, input logic [COUNT_W-1:0] limit);
      settle();
      write_csr(CSR_DROP_POLICY, CSR_DATA_W'(drop));
      write_csr(CSR_QUEUE_MAX, limit);
      cur_max = limit;
   endtask

   // random transactions, mostly on a few hot counters so they build up
   task automatic random_txns(input int count);
      int                 pick;
      int                 span;
      logic [FUNC_W-1:0]  op;
      logic [PORT_W-1:0]  port;
      logic [VC_W-1:0]    vc;
      logic [BYTES_W-1:0] nbytes;
      logic [COUNT_W-1:0] queued;
      logic               present;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         op = (pick < 45) ? FUNC_RESERVE : (pick < 70) ? FUNC_RELEASE :
              (pick < 95) ? FUNC_QUERY : FUNC_SPARE;
         if ($urandom_range(0, 9) < 6) begin
            port = PORT_W'($urandom_range(0, 1));
            vc = VC_W'($urandom_range(0, 1));
         end else begin
            port = PORT_W'($urandom);
            vc = VC_W'($urandom);
         end
         case ($urandom_range(0, 9))
            0:       nbytes = '0;
            1:       nbytes = '1;
            default: nbytes = BYTES_W'($urandom);
         endcase
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            queued = $urandom;
         end else if (pick < 6) begin
            // close to the limit
            span = $urandom_range(0, 70000);
            queued = (cur_max > COUNT_W'(span)) ? cur_max - COUNT_W'(span) : '0;
         end else begin
            queued = $urandom_range(0, cur_max >> 1);
         end
         present = ($urandom_range(0, 9) != 0);
         offer_txn(op, port, vc, nbytes, queued, present);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // retry policy after reset: reserve admits and leaves counters at zero
      offer_txn(FUNC_RESERVE, 4'd15, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      offer_txn(FUNC_QUERY,   4'd15, 3'd7, 16'h0000, 32'h0000_0000, 1'b1);
      offer_txn(FUNC_RELEASE, 4'd0,  3'd0, 16'hFFFF, 32'h0000_0000, 1'b1);
      offer_txn(FUNC_SPARE,   4'd3,  3'd5, 16'h1234, 32'h0000_0000, 1'b1);

      // drop policy at the reset limit: admit, absent target, overflow, boundary
      set_policy(1'b1, QUEUE_MAX_RESET);
      offer_txn(FUNC_RESERVE, 4'd15, 3'd7, 16'hFFFF, 32'h0000_0000, 1'b1);
      offer_txn(FUNC_RESERVE, 4'd15, 3'd7, 16'hFFFF, 32'h0000_0000, 1'b0);
      offer_txn(FUNC_RESERVE, 4'd15, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      offer_txn(FUNC_RESERVE, 4'd15, 3'd7, 16'h0000, QUEUE_MAX_RESET - 32'd65535, 1'b1);
      offer_txn(FUNC_RESERVE, 4'd15, 3'd7, 16'h0001, QUEUE_MAX_RESET - 32'd65535, 1'b1);
      offer_txn(FUNC_RELEASE, 4'd15, 3'd7, 16'd1000, 32'h0000_0000, 1'b1);
      offer_txn(FUNC_QUERY,   4'd15, 3'd7, 16'h0000, 32'h0000_0000, 1'b1);
      offer_txn(FUNC_RELEASE, 4'd15, 3'd7, 16'hFFFF, 32'h0000_0000, 1'b1);
      offer_txn(FUNC_RESERVE, 4'd0,  3'd0, 16'h0000, 32'h0000_0000, 1'b1);

      // zero limit: only an empty reserve on an empty queue gets in
      set_policy(1'b1, '0);
      offer_txn(FUNC_RESERVE, 4'd0, 3'd0, 16'h0000, 32'h0000_0000, 1'b1);
      offer_txn(FUNC_RESERVE, 4'd0, 3'd0, 16'h0001, 32'h0000_0000, 1'b1);
      offer_txn(FUNC_RESERVE, 4'd8, 3'd3, 16'h0000, 32'h0000_0001, 1'b1);

      // full-scale limit: sum landing exactly on it, then one past
      set_policy(1'b1, '1);
      offer_txn(FUNC_RESERVE, 4'd1, 3'd1, 16'hFFFF, 32'hFFFF_0000, 1'b1);
      offer_txn(FUNC_RESERVE, 4'd1, 3'd1, 16'h0001, 32'hFFFF_0000, 1'b1);
      offer_txn(FUNC_SPARE,   4'd1, 3'd1, 16'h0000, 32'h0000_0000, 1'b1);
      offer_txn(FUNC_RELEASE, 4'd1, 3'd1, 16'hFFFE, 32'h0000_0000, 1'b1);

      // random phases; the first and last start under a long response hold-off
      set_policy(1'b1, QUEUE_MAX_RESET);
      hold_off_req = 1'b1;
      random_txns(90);
      set_policy(1'b0, QUEUE_MAX_RESET);
      random_txns(80);
      set_policy(1'b1, 32'd300000);
      random_txns(90);
      set_policy(1'b1, '1);
      random_txns(80);
      set_policy(1'b1, '0);
      random_txns(40);
      set_policy(1'b1, QUEUE_MAX_RESET);
      hold_off_req = 1'b1;
      random_txns(70);

      settle();
      $display("covered %0d transactions under retry and drop admission", checked_count);
      $display("queue limits 0 to full scale, %0d reserves refused", refused_count);
      if (fail_count == 0 && backlog == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ egress_vc_byte_admission.f @@
hw/rtl/evba_pkg.sv
hw/rtl/egress_vc_byte_admission.sv
tb/evba_admission_checker.sv
tb/egress_vc_byte_admission_tb.sv
